>>> sv/pqem_pkg.sv
// Shared types and constants for the max-first priority queue.
// Holds field widths, operation and status codes, and the cell link structs.
// No dependencies.
`default_nettype none

package pqem_pkg;

    localparam int OPERATION_BITS      = 2;
    localparam int VALUE_FIELD_BITS    = 16;
    localparam int PRIORITY_FIELD_BITS = 8;
    localparam int STATUS_BITS         = 2;
    localparam int COUNT_FIELD_BITS    = 6;

    typedef enum logic [OPERATION_BITS-1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell in the chain for one cycle.
    typedef struct packed {
        logic insert;
        logic extract;
        logic clear;
    } cell_cmd_t;

    // Control handed from a cell to its downstream neighbor.
    typedef struct packed {
        logic valid;
        logic yield;
    } link_t;

endpackage

`default_nettype wire

>>> sv/pqem_req_if.sv
// Request channel of the priority queue: valid/ready handshake plus payload.
// Depends on pqem_pkg for field widths.
`default_nettype none

interface pqem_req_if;
    logic                                      valid;
    logic                                      ready;
    logic [pqem_pkg::OPERATION_BITS-1:0]       operation;
    logic [pqem_pkg::VALUE_FIELD_BITS-1:0]     item_value;
    logic [pqem_pkg::PRIORITY_FIELD_BITS-1:0]  item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

`default_nettype wire

>>> sv/pqem_rsp_if.sv
// Result channel of the priority queue: valid/ready handshake plus payload.
// Depends on pqem_pkg for field widths.
`default_nettype none

interface pqem_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [pqem_pkg::VALUE_FIELD_BITS-1:0]  out_value;
    logic [pqem_pkg::STATUS_BITS-1:0]       status;
    logic [pqem_pkg::COUNT_FIELD_BITS-1:0]  entry_count;
    logic                                   is_full;

    modport source (output valid, output out_value, output status,
                    output entry_count, output is_full, input ready);
    modport sink   (input valid, input out_value, input status,
                    input entry_count, input is_full, output ready);
endinterface

`default_nettype wire

>>> sv/priority_queue_extract_max.sv
// A result is registered and presented in the cycle after its request transaction.
// Throughput: one transaction per cycle while results are taken without a stall; every cell of
// the sorted chain updates in parallel each cycle (insert shifts the tail, extract pops the head).
// A new request enters in the cycle the waiting result is taken; a stalled result holds it off.
// Reset clears the cell valid bits and the entry count at once; no clearing pass.
// Depends on pqem_pkg, pqem_req_if, pqem_rsp_if and pqem_cell.
`default_nettype none

module priority_queue_extract_max #(
    parameter int CAPACITY      = 32,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pqem_req_if.sink    request,
    pqem_rsp_if.source  result
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CNT_WIDE = CNT_W + pqem_pkg::COUNT_FIELD_BITS;

    logic [CNT_W-1:0]                         count_reg;
    logic [CNT_W-1:0]                         count_next;
    logic                                     res_valid_reg;
    logic [pqem_pkg::VALUE_FIELD_BITS-1:0]    out_value_reg;
    logic [pqem_pkg::VALUE_FIELD_BITS-1:0]    out_value_next;
    pqem_pkg::status_t                        status_reg;
    pqem_pkg::status_t                        status_next;
    logic [pqem_pkg::COUNT_FIELD_BITS-1:0]    entry_count_reg;
    logic                                     is_full_reg;

    logic                                     accept;
    logic                                     full;
    logic                                     empty;
    pqem_pkg::cell_cmd_t                      cmd;
    logic [31:0]                              in_value_wide;
    logic [15:0]                              in_prio_wide;
    logic [VALUE_BITS-1:0]                    new_value;
    logic [PRIORITY_BITS-1:0]                 new_prio;
    logic [31:0]                              head_value_wide;
    logic [CNT_WIDE-1:0]                      count_wide;

    pqem_pkg::link_t                          link_w  [CAPACITY];
    logic [VALUE_BITS-1:0]                    value_w [CAPACITY];
    logic [PRIORITY_BITS-1:0]                 prio_w  [CAPACITY];
    logic [CAPACITY-1:0]                      valid_vec;

    assign accept        = request.valid && request.ready;
    assign request.ready = !res_valid_reg || result.ready;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign in_value_wide   = 32'(request.item_value);
    assign in_prio_wide    = 16'(request.item_priority);
    assign new_value       = in_value_wide[VALUE_BITS-1:0];
    assign new_prio        = in_prio_wide[PRIORITY_BITS-1:0];
    assign head_value_wide = 32'(value_w[0]);

    always_comb
    begin
        cmd            = '0;
        count_next     = count_reg;
        status_next    = pqem_pkg::ST_DONE;
        out_value_next = '0;
        unique case (request.operation)
            pqem_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = pqem_pkg::ST_FULL;
                end
                else
                begin
                    cmd.insert = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            pqem_pkg::OP_EXTRACT:
            begin
                if (empty)
                begin
                    status_next = pqem_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.extract    = accept;
                    count_next     = count_reg - 1'b1;
                    out_value_next = head_value_wide[pqem_pkg::VALUE_FIELD_BITS-1:0];
                end
            end
            pqem_pkg::OP_CLEAR:
            begin
                cmd.clear  = accept;
                count_next = '0;
            end
            default:
            begin
                // unused code: leave the queue alone
                count_next = count_reg;
            end
        endcase
    end

    assign count_wide = CNT_WIDE'(count_next);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pqem_pkg::link_t          up_link;
        logic [VALUE_BITS-1:0]    up_value;
        logic [PRIORITY_BITS-1:0] up_prio;
        logic                     dn_valid;
        logic [VALUE_BITS-1:0]    dn_value;
        logic [PRIORITY_BITS-1:0] dn_prio;

        if (i == 0)
        begin : g_head
            assign up_link  = '0;
            assign up_value = '0;
            assign up_prio  = '0;
        end
        else
        begin : g_up
            assign up_link  = link_w[i-1];
            assign up_value = value_w[i-1];
            assign up_prio  = prio_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign dn_valid = 1'b0;
            assign dn_value = '0;
            assign dn_prio  = '0;
        end
        else
        begin : g_dn
            assign dn_valid = link_w[i+1].valid;
            assign dn_value = value_w[i+1];
            assign dn_prio  = prio_w[i+1];
        end

        pqem_cell #(
            .VALUE_BITS    (VALUE_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_value  (new_value),
            .new_prio   (new_prio),
            .up_link    (up_link),
            .up_value   (up_value),
            .up_prio    (up_prio),
            .dn_valid   (dn_valid),
            .dn_value   (dn_value),
            .dn_prio    (dn_prio),
            .link       (link_w[i]),
            .cell_value (value_w[i]),
            .cell_prio  (prio_w[i])
        );

        assign valid_vec[i] = link_w[i].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until its transaction completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg   <= out_value_next;
            status_reg      <= status_next;
            entry_count_reg <= count_wide[pqem_pkg::COUNT_FIELD_BITS-1:0];
            is_full_reg     <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.out_value   = out_value_reg;
    assign result.status      = status_reg;
    assign result.entry_count = entry_count_reg;
    assign result.is_full     = is_full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_extract_pops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.operation == pqem_pkg::OP_EXTRACT) && !empty
        |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("extract did not remove one entry");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.operation == pqem_pkg::OP_INSERT) && full
        |=> (count_reg == $past(count_reg)) && (status_reg == pqem_pkg::ST_FULL))
        else $error("insert into full queue was not dropped");

endmodule

`default_nettype wire

>>> sv/pqem_cell.sv
// One slot of the sorted cell chain: holds a value, its priority and a valid bit.
// Depends on pqem_pkg for the command and link structs.
`default_nettype none

module pqem_cell #(
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pqem_pkg::cell_cmd_t      cmd,
    input  wire logic [VALUE_BITS-1:0]    new_value,
    input  wire logic [PRIORITY_BITS-1:0] new_prio,
    input  wire pqem_pkg::link_t          up_link,
    input  wire logic [VALUE_BITS-1:0]    up_value,
    input  wire logic [PRIORITY_BITS-1:0] up_prio,
    input  wire logic                     dn_valid,
    input  wire logic [VALUE_BITS-1:0]    dn_value,
    input  wire logic [PRIORITY_BITS-1:0] dn_prio,
    output pqem_pkg::link_t               link,
    output logic [VALUE_BITS-1:0]         cell_value,
    output logic [PRIORITY_BITS-1:0]      cell_prio
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [VALUE_BITS-1:0]    value_reg;
    logic [VALUE_BITS-1:0]    value_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    // Give way to a new entry of strictly higher priority; equal ones queue behind.
    assign link.valid = valid_reg;
    assign link.yield = !valid_reg || (prio_reg < new_prio);

    assign cell_value = value_reg;
    assign cell_prio  = prio_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        priority if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.extract)
        begin
            // advance toward the head
            valid_next = dn_valid;
            value_next = dn_value;
            prio_next  = dn_prio;
        end
        else if (cmd.insert && link.yield)
        begin
            if (up_link.yield)
            begin
                // shift the upstream entry down by one
                valid_next = up_link.valid;
                value_next = up_value;
                prio_next  = up_prio;
            end
            else
            begin
                // first cell that yields takes the new entry
                valid_next = 1'b1;
                value_next = new_value;
                prio_next  = new_prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

`default_nettype wire
